// File: design/worc_pkg.sv
`timescale 1ns / 1ps
package worc_pkg;
    localparam int NUM_FEATURES = 8;
    localparam int FIDX_W = 3;
    localparam int FEAT_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_FORGET    = 3'd1;
    localparam logic [2:0] CFG_GAIN      = 3'd2;
    localparam logic [2:0] CFG_WEIGHT    = 3'd3;
    localparam logic [2:0] CFG_CORRECT   = 3'd4;

    localparam logic [31:0] THRESHOLD_RST = 32'd589824;
    localparam logic [16:0] FORGET_RST    = 17'd64881;
    localparam logic [31:0] GAIN_RST      = 32'd65536;
endpackage

// File: design/welford_outlier_rls_corrector_core.sv
`timescale 1ns / 1ps
// Per-feature outlier detector with scalar RLS replacement.
// Input channel s_*: feature index and signed Q16.16 sample, valid/ready.
// Result channel m_*: feature index, corrected sample and outlier flag.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// the user must write only while no word is in flight (not enforced here).
// One word is worked on at a time; s_ready is high only in the idle state.
// A valid feature index runs, from the accepting edge to m_valid, through
// a 32-step restoring division for the mean step, the mean update,
// products and compare on one shared 32x32 multiplier, a 48-step division
// for the RLS gain, and the steps that update the estimate and load the
// output. An index beyond the feature count goes from the idle state
// straight to the done state, passing the sample through unflagged.
// The result sits in an output register until m_ready; meanwhile one
// further word can be taken and is held at its last step, with s_ready low,
// until the register frees. Reset clears the per-feature state and restores
// the register reset values; m_valid is low after reset.
module welford_outlier_rls_corrector_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [worc_pkg::FIDX_W-1:0] s_feature_index,
    input  logic signed [31:0] s_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [worc_pkg::FIDX_W-1:0] m_out_feature_index,
    output logic signed [31:0] m_corrected_sample,
    output logic        m_is_outlier
);
    localparam int NF = worc_pkg::NUM_FEATURES;
    localparam int FW = worc_pkg::FEAT_W;

    localparam logic [3:0] S_IDLE = 4'd0, S_MDIV = 4'd1, S_MEAN = 4'd2, S_RES = 4'd3,
                           S_PROD = 4'd4, S_SQ = 4'd5, S_L0 = 4'd6, S_L1 = 4'd7,
                           S_R0 = 4'd8, S_R1 = 4'd9, S_CMP = 4'd10, S_KDIV = 4'd11,
                           S_ERR = 4'd12, S_STEP = 4'd13, S_DONE = 4'd14;

    // configuration
    logic [31:0] thr_reg;
    logic [16:0] mu_reg;
    logic [31:0] gain0_reg;
    logic [31:0] w0_reg;
    logic        corr_reg;

    // per-feature state
    logic [31:0] cnt_reg  [NF];
    logic [31:0] mean_reg [NF];
    logic [63:0] dev_reg  [NF];
    logic [31:0] w_reg    [NF];
    logic [31:0] p_reg    [NF];

    // working registers of the word in flight
    logic [3:0]  st_reg;
    logic [worc_pkg::FIDX_W-1:0] fidx_reg;
    logic [FW-1:0] f_reg;
    logic [31:0] x_reg;
    logic [31:0] n_reg;
    logic [31:0] wcur_reg, pcur_reg;
    logic        neg_reg;
    logic [31:0] dm_reg, rm_reg;
    logic [63:0] sq_reg;
    logic [95:0] lhs_reg, rhs_reg;
    logic        flag_reg;
    logic [31:0] xc_reg;
    logic        den_zero_reg;
    logic        eneg_reg;
    logic [31:0] em_reg;
    logic [16:0] k_reg;

    // shared divider: 48-bit dividend, 33-bit divisor
    logic [47:0] div_quo_reg;
    logic [32:0] div_rem_reg;
    logic [32:0] div_den_reg;
    logic [5:0]  div_cnt_reg;

    // output register
    logic [worc_pkg::FIDX_W-1:0] out_f_reg;
    logic [31:0] out_x_reg;
    logic        out_o_reg, out_v_reg;

    logic [FW-1:0] in_f;
    logic          in_ok;
    logic [31:0]   cnt_in, n_in, mean_in, dm_in;
    logic [32:0]   delta_in, delta_neg;
    logic [31:0]   mean_cur, mean_new;
    logic [63:0]   dev_cur;
    logic [32:0]   r_c, r_neg;
    logic [64:0]   dev_sum;
    logic [31:0]   nm1;
    logic [32:0]   den_c;
    logic          flag_c;
    logic [32:0]   err_c, err_neg;
    logic [16:0]   k_val;
    logic [31:0]   step_c, w_new;
    logic [34:0]   div_trial;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_out;
    logic          out_load;

    assign s_ready = (st_reg == S_IDLE);
    assign m_valid = out_v_reg;
    assign m_out_feature_index = out_f_reg;
    assign m_corrected_sample = out_x_reg;
    assign m_is_outlier = out_o_reg;

    // incoming word: new count and distance from the old mean
    assign in_f = FW'(s_feature_index);
    assign in_ok = (32'(s_feature_index) < 32'(NF));
    assign cnt_in = cnt_reg[in_f];
    assign n_in = cnt_in + {31'd0, cnt_in != '1};
    assign mean_in = mean_reg[in_f];
    assign delta_in = {s_sample[31], s_sample} - {mean_in[31], mean_in};
    assign delta_neg = 33'd0 - delta_in;
    assign dm_in = delta_in[32] ? delta_neg[31:0] : delta_in[31:0];

    // mean step, residual and saturating deviation sum
    assign mean_cur = mean_reg[f_reg];
    assign dev_cur = dev_reg[f_reg];
    assign mean_new = neg_reg ? mean_cur - div_quo_reg[31:0] : mean_cur + div_quo_reg[31:0];
    assign r_c = {x_reg[31], x_reg} - {mean_cur[31], mean_cur};
    assign r_neg = 33'd0 - r_c;
    assign dev_sum = {1'b0, dev_cur} + {1'b0, mul_out};
    assign nm1 = n_reg - 32'd1;

    // outlier test and RLS gain divisor
    assign flag_c = (n_reg >= 32'd2) && (dev_cur != 64'd0)
                    && ({lhs_reg, 16'd0} > {16'd0, rhs_reg});
    assign den_c = {16'd0, mu_reg} + {1'b0, pcur_reg};

    // estimate update
    assign err_c = {xc_reg[31], xc_reg} - {wcur_reg[31], wcur_reg};
    assign err_neg = 33'd0 - err_c;
    assign k_val = den_zero_reg ? 17'd0 : div_quo_reg[16:0];
    assign step_c = mul_out[47:16];
    assign w_new = eneg_reg ? wcur_reg - step_c : wcur_reg + step_c;

    // one restoring division step
    assign div_trial = {1'b0, div_rem_reg, div_quo_reg[47]} - {2'd0, div_den_reg};

    // select the operands of the shared multiplier
    always_comb begin
        case (st_reg)
            S_PROD: begin
                mul_a = dm_reg;
                mul_b = rm_reg;
            end
            S_SQ: begin
                mul_a = rm_reg;
                mul_b = rm_reg;
            end
            S_L0: begin
                mul_a = sq_reg[31:0];
                mul_b = nm1;
            end
            S_L1: begin
                mul_a = sq_reg[63:32];
                mul_b = nm1;
            end
            S_R0: begin
                mul_a = dev_cur[31:0];
                mul_b = thr_reg;
            end
            S_R1: begin
                mul_a = dev_cur[63:32];
                mul_b = thr_reg;
            end
            S_STEP: begin
                mul_a = em_reg;
                mul_b = {15'd0, k_reg};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end
    assign mul_out = {32'd0, mul_a} * {32'd0, mul_b};

    assign out_load = (st_reg == S_DONE) && (!out_v_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= worc_pkg::THRESHOLD_RST;
            mu_reg <= worc_pkg::FORGET_RST;
            gain0_reg <= worc_pkg::GAIN_RST;
            w0_reg <= '0;
            corr_reg <= 1'b1;
            st_reg <= S_IDLE;
            out_v_reg <= 1'b0;
            out_f_reg <= '0;
            out_x_reg <= '0;
            out_o_reg <= 1'b0;
            for (int i = 0; i < NF; i++) begin
                cnt_reg[i] <= '0;
                mean_reg[i] <= '0;
                dev_reg[i] <= '0;
                w_reg[i] <= '0;
                p_reg[i] <= '0;
            end
        end else begin
            // take configuration writes
            if (cfg_we) begin
                case (cfg_index)
                    worc_pkg::CFG_THRESHOLD: thr_reg <= cfg_data;
                    worc_pkg::CFG_FORGET:    mu_reg <= cfg_data[16:0];
                    worc_pkg::CFG_GAIN:      gain0_reg <= cfg_data;
                    worc_pkg::CFG_WEIGHT:    w0_reg <= cfg_data;
                    worc_pkg::CFG_CORRECT:   corr_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            // load the result word, or drop it once taken
            if (out_load) begin
                out_v_reg <= 1'b1;
                out_f_reg <= fidx_reg;
                out_x_reg <= xc_reg;
                out_o_reg <= flag_reg;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        fidx_reg <= s_feature_index;
                        x_reg <= s_sample;
                        if (!in_ok) begin
                            xc_reg <= s_sample;
                            flag_reg <= 1'b0;
                            st_reg <= S_DONE;
                        end else begin
                            f_reg <= in_f;
                            n_reg <= n_in;
                            wcur_reg <= (cnt_in == 32'd0) ? w0_reg : w_reg[in_f];
                            pcur_reg <= (cnt_in == 32'd0) ? gain0_reg : p_reg[in_f];
                            neg_reg <= delta_in[32];
                            dm_reg <= dm_in;
                            div_quo_reg <= {dm_in, 16'd0};
                            div_rem_reg <= '0;
                            div_den_reg <= {1'b0, n_in};
                            div_cnt_reg <= 6'd32;
                            st_reg <= S_MDIV;
                        end
                    end
                end
                S_MDIV, S_KDIV: begin
                    // advance the divider one quotient bit
                    if (!div_trial[34]) begin
                        div_rem_reg <= div_trial[32:0];
                        div_quo_reg <= {div_quo_reg[46:0], 1'b1};
                    end else begin
                        div_rem_reg <= {div_rem_reg[31:0], div_quo_reg[47]};
                        div_quo_reg <= {div_quo_reg[46:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == 6'd1) st_reg <= (st_reg == S_MDIV) ? S_MEAN : S_ERR;
                end
                S_MEAN: begin
                    mean_reg[f_reg] <= mean_new;
                    st_reg <= S_RES;
                end
                S_RES: begin
                    rm_reg <= r_c[32] ? r_neg[31:0] : r_c[31:0];
                    st_reg <= S_PROD;
                end
                S_PROD: begin
                    // saturate the deviation sum
                    dev_reg[f_reg] <= dev_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dev_sum[63:0];
                    st_reg <= S_SQ;
                end
                S_SQ: begin
                    sq_reg <= mul_out;
                    st_reg <= S_L0;
                end
                S_L0: begin
                    lhs_reg <= {32'd0, mul_out};
                    st_reg <= S_L1;
                end
                S_L1: begin
                    lhs_reg[95:32] <= lhs_reg[95:32] + mul_out;
                    st_reg <= S_R0;
                end
                S_R0: begin
                    rhs_reg <= {32'd0, mul_out};
                    st_reg <= S_R1;
                end
                S_R1: begin
                    rhs_reg[95:32] <= rhs_reg[95:32] + mul_out;
                    st_reg <= S_CMP;
                end
                S_CMP: begin
                    // pick the value passed on and start the gain division
                    flag_reg <= flag_c;
                    xc_reg <= (flag_c && corr_reg) ? wcur_reg : x_reg;
                    den_zero_reg <= (den_c == 33'd0);
                    div_quo_reg <= {pcur_reg, 16'd0};
                    div_rem_reg <= '0;
                    div_den_reg <= den_c;
                    div_cnt_reg <= 6'd48;
                    st_reg <= S_KDIV;
                end
                S_ERR: begin
                    p_reg[f_reg] <= {15'd0, k_val};
                    k_reg <= k_val;
                    eneg_reg <= err_c[32];
                    em_reg <= err_c[32] ? err_neg[31:0] : err_c[31:0];
                    st_reg <= S_STEP;
                end
                S_STEP: begin
                    w_reg[f_reg] <= w_new;
                    cnt_reg[f_reg] <= n_reg;
                    st_reg <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_load) st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_corrected_sample)
                                && $stable(m_out_feature_index) && $stable(m_is_outlier));
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready);
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready);
endmodule
